// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

  // Storage depth and stored value width
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;

  // Port field widths
  localparam int FIELD_W = 32;
  localparam int FUNC_W  = 3;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_ADD_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] OP_REM_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_REVERSE   = 3'd4;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic shift_up;    // insert at physical head, all cells move up
    logic shift_down;  // remove at physical head, all cells move down
    logic put_tail;    // write the new value at position count
    cnt_t count;       // values held before this transaction
    val_t value;       // value carried by this transaction
  } bdq_ctrl_t;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
module bdq_cell (
  input  logic                    clk,
  input  bdq_pkg::bdq_ctrl_t      ctrl_i,
  input  logic [bdq_pkg::IDX_W-1:0] idx_i,
  input  bdq_pkg::val_t           prev_i,
  input  bdq_pkg::val_t           next_i,
  output bdq_pkg::val_t           data_o,
  output bdq_pkg::val_t           tail_o
);
  import bdq_pkg::*;

  val_t data_r;
  val_t data_nxt;
  cnt_t my_pos;
  logic is_tail;

  assign my_pos  = CNT_W'(idx_i);
  assign is_tail = (ctrl_i.count == (my_pos + CNT_W'(1)));

  // Take from a neighbor on a shift, or load the value at the tail slot
  always_comb begin
    data_nxt = data_r;
    if (ctrl_i.shift_up) begin
      data_nxt = prev_i;
    end else if (ctrl_i.shift_down) begin
      data_nxt = next_i;
    end else if (ctrl_i.put_tail && (ctrl_i.count == my_pos)) begin
      data_nxt = ctrl_i.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign tail_o = is_tail ? data_r : '0;

endmodule

// ===== hw/rtl/bounded_deque_with_reverse_unit.sv =====
// Channel  Ports                                   Handshake
// input    in_func, in_value                       start high while busy low
// result   out_front_value, out_back_value,        out_valid, one cycle only
//          out_is_empty, out_occupancy, out_dropped
//
// One transaction per cycle while busy is low. The cell chain updates at the
// accept edge; pend_r and then valid_r follow, and the result register loads
// with valid_r, from the state the transaction left. busy is high in reset and
// until the first edge out of it; the result side takes every result as shown.
// Reset clears count and direction, not cells; only held slots are ever read.
module bounded_deque_with_reverse_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bdq_pkg::FUNC_W-1:0]    in_func,
  input  logic [bdq_pkg::FIELD_W-1:0]   in_value,
  output logic                          out_valid,
  output logic [bdq_pkg::FIELD_W-1:0]   out_front_value,
  output logic [bdq_pkg::FIELD_W-1:0]   out_back_value,
  output logic                          out_is_empty,
  output logic [bdq_pkg::CNT_W-1:0]     out_occupancy,
  output logic                          out_dropped
);
  import bdq_pkg::*;

  logic busy_r;
  cnt_t count_r, count_nxt;
  logic rev_r, rev_nxt;
  logic pend_r, pend_drop_r;
  logic valid_r, dropped_r, empty_r;
  logic [FIELD_W-1:0] front_r, back_r;
  cnt_t occ_r;

  logic acc, full, empty, is_add, is_rem, at_head, drop;
  bdq_ctrl_t ctrl;

  val_t data_w [DEPTH];
  val_t tail_w [DEPTH];
  val_t head_v, tail_v;

  // Decode the transaction against the current direction
  assign acc    = start && !busy_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign is_add = (in_func == OP_ADD_FRONT) || (in_func == OP_ADD_BACK);
  assign is_rem = (in_func == OP_REM_FRONT) || (in_func == OP_REM_BACK);
  assign at_head = ((in_func == OP_ADD_FRONT) || (in_func == OP_REM_FRONT)) != rev_r;
  assign drop   = acc && is_add && full;

  always_comb begin
    ctrl.shift_up   = acc && is_add && !full && at_head;
    ctrl.put_tail   = acc && is_add && !full && !at_head;
    ctrl.shift_down = acc && is_rem && !empty && at_head;
    ctrl.count      = count_r;
    ctrl.value      = VALUE_BITS'(in_value);
  end

  // Advance count and direction
  always_comb begin
    count_nxt = count_r;
    rev_nxt   = rev_r;
    if (ctrl.shift_up || ctrl.put_tail) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (acc && is_rem && !empty) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (acc && (in_func == OP_REVERSE)) begin
      rev_nxt = !rev_r;
    end
  end

  // Cell chain: cell 0 holds the physical head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    val_t prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = ctrl.value;
    end else begin : g_mid
      assign prev_v = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_v = data_w[g];
    end else begin : g_inner
      assign next_v = data_w[g+1];
    end
    bdq_cell u_cell (
      .clk    (clk),
      .ctrl_i (ctrl),
      .idx_i  (IDX_W'(g)),
      .prev_i (prev_v),
      .next_i (next_v),
      .data_o (data_w[g]),
      .tail_o (tail_w[g])
    );
  end

  // Gather the physical tail from the one selected cell
  always_comb begin
    tail_v = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_v = tail_v | tail_w[i];
    end
    head_v = empty ? '0 : data_w[0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      count_r <= '0;
      rev_r   <= 1'b0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      pend_r  <= acc;
      valid_r <= pend_r;
    end
  end

  // Result register, loaded from the state left by the previous transaction
  always_ff @(posedge clk) begin
    pend_drop_r <= drop;
    dropped_r   <= pend_drop_r;
    empty_r     <= empty;
    occ_r       <= count_r;
    front_r     <= FIELD_W'(rev_r ? tail_v : head_v);
    back_r      <= FIELD_W'(rev_r ? head_v : tail_v);
  end

  assign busy            = busy_r;
  assign out_valid       = valid_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_is_empty    = empty_r;
  assign out_occupancy   = occ_r;
  assign out_dropped     = dropped_r;

endmodule
